// ----- rtl/ssdm_pkg.sv -----
// shared types and constants for the stream suffix dictionary matcher
`timescale 1ns / 1ps

package ssdm_pkg;

    localparam int NODE_COUNT    = 1024;
    localparam int MAX_LEN       = 32;
    localparam int ALPHABET_SIZE = 26;

    localparam int LETTER_W = 5;
    localparam int STATUS_W = 2;
    localparam int NODE_W   = $clog2(NODE_COUNT);
    localparam int CNT_W    = $clog2(NODE_COUNT + 1);
    localparam int LEN_W    = $clog2(MAX_LEN + 1);
    localparam int POS_W    = $clog2(MAX_LEN);

    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_LONG = 2'd2;

    typedef enum logic [1:0] {
        CMD_INSERT,
        CMD_SKIP,
        CMD_QUERY
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t             kind;
        logic [LETTER_W-1:0]   letter;
        logic                  last;
    } cmd_t;

    typedef struct packed {
        logic                                  mark;
        logic [ALPHABET_SIZE-1:0][NODE_W-1:0]  child;
    } trie_row_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_Q_WALK,
        ST_I_LOOK,
        ST_I_NEW,
        ST_I_MARK
    } back_state_t;

endpackage

// ----- rtl/ssdm_front.sv -----
// input classifier and command queue of the suffix matcher
`timescale 1ns / 1ps

module ssdm_front import ssdm_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // [4:0] letter, [7:5] zero
    input  logic                s_tlast,
    input  logic                s_tuser,   // [0] req_type
    input  logic                init_done,
    output logic                cmd_valid,
    output cmd_t                cmd,
    input  logic                cmd_pop
);

    cmd_t                queue_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                push;
    logic                pop;
    cmd_t                beat_cmd;
    logic [LETTER_W-1:0] beat_letter;

    assign beat_letter = s_tdata[LETTER_W-1:0];

    // out-of-range insert letters are dropped, word_end included
    always_comb begin
        beat_cmd.letter = beat_letter;
        beat_cmd.last   = s_tlast;
        if (s_tuser) begin
            beat_cmd.kind = CMD_QUERY;
        end else if (beat_letter >= LETTER_W'(ALPHABET_SIZE)) begin
            beat_cmd.kind = CMD_SKIP;
        end else begin
            beat_cmd.kind = CMD_INSERT;
        end
    end

    assign s_tready  = init_done && (count_reg != QCNT_W'(QDEPTH));
    assign push      = s_tvalid && s_tready;
    assign cmd_valid = (count_reg != '0);
    assign cmd       = queue_reg[rd_ptr_reg];
    assign pop       = cmd_pop && cmd_valid;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= beat_cmd;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("command queue count out of range");

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == QCNT_W'(QDEPTH) && !pop) |=> count_reg == QCNT_W'(QDEPTH))
        else $error("command queue lost an entry while full");

    a_pop_moves_ptr: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> rd_ptr_reg == $past(rd_ptr_reg) + 1'b1)
        else $error("read pointer did not advance on pop");

endmodule

// ----- rtl/ssdm_back.sv -----
// trie engine: word insertion, stream history and suffix walk
`timescale 1ns / 1ps

module ssdm_back import ssdm_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cmd_valid,
    input  cmd_t                cmd,
    output logic                cmd_pop,
    output logic                init_done,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata    // [0] match, [2:1] status, [7:3] zero
);

    trie_row_t              trie_mem [NODE_COUNT];
    trie_row_t              rd_row_reg;
    logic                   mem_we;
    logic [NODE_W-1:0]      mem_waddr;
    trie_row_t              mem_wdata;
    logic [NODE_W-1:0]      mem_raddr;

    logic [LETTER_W-1:0]    ring_reg [MAX_LEN];
    logic                   ring_we;

    back_state_t            state_reg, state_next;
    logic [CNT_W-1:0]       nodes_used_reg, nodes_used_next;
    logic [NODE_W-1:0]      cursor_reg, cursor_next;
    logic [LEN_W-1:0]       length_reg, length_next;
    logic [STATUS_W-1:0]    err_reg, err_next;
    logic [POS_W-1:0]       head_reg, head_next;
    logic [LEN_W-1:0]       fill_reg, fill_next;
    logic [LEN_W-1:0]       level_reg, level_next;
    logic [POS_W-1:0]       pos_reg, pos_next;
    logic [NODE_W-1:0]      new_node_reg, new_node_next;
    logic [LETTER_W-1:0]    cmd_letter_reg, cmd_letter_next;
    logic                   cmd_last_reg, cmd_last_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   out_match_reg, out_match_next;
    logic [STATUS_W-1:0]    out_status_reg, out_status_next;

    logic [LETTER_W-1:0]    walk_letter;
    logic [NODE_W-1:0]      walk_child;
    logic [NODE_W-1:0]      look_child;

    assign walk_letter = ring_reg[pos_reg];
    assign walk_child  = (walk_letter < LETTER_W'(ALPHABET_SIZE))
                         ? rd_row_reg.child[walk_letter] : '0;
    assign look_child  = (cmd_letter_reg < LETTER_W'(ALPHABET_SIZE))
                         ? rd_row_reg.child[cmd_letter_reg] : '0;

    assign init_done = (state_reg != ST_CLEAR);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {5'b0, out_status_reg, out_match_reg};

    always_comb begin
        state_next      = state_reg;
        nodes_used_next = nodes_used_reg;
        cursor_next     = cursor_reg;
        length_next     = length_reg;
        err_next        = err_reg;
        head_next       = head_reg;
        fill_next       = fill_reg;
        level_next      = level_reg;
        pos_next        = pos_reg;
        new_node_next   = new_node_reg;
        cmd_letter_next = cmd_letter_reg;
        cmd_last_next   = cmd_last_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_match_next  = out_match_reg;
        out_status_next = out_status_reg;
        mem_we          = 1'b0;
        mem_waddr       = cursor_reg;
        mem_wdata       = rd_row_reg;
        mem_raddr       = '0;
        ring_we         = 1'b0;
        cmd_pop         = 1'b0;

        unique case (state_reg)
            ST_CLEAR: begin
                // root row only; every other row is cleared when allocated
                mem_we     = 1'b1;
                mem_waddr  = '0;
                mem_wdata  = '0;
                state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (cmd_valid && !out_valid_reg) begin
                    cmd_pop         = 1'b1;
                    cmd_letter_next = cmd.letter;
                    cmd_last_next   = cmd.last;
                    unique case (cmd.kind)
                        CMD_QUERY: begin
                            ring_we   = 1'b1;
                            head_next = (head_reg == POS_W'(MAX_LEN - 1))
                                        ? '0 : head_reg + 1'b1;
                            if (fill_reg < LEN_W'(MAX_LEN)) begin
                                fill_next = fill_reg + 1'b1;
                            end
                            mem_raddr  = '0;
                            level_next = '0;
                            pos_next   = head_reg;
                            state_next = ST_Q_WALK;
                        end
                        CMD_INSERT: begin
                            if (err_reg != STATUS_OK) begin
                                out_valid_next  = 1'b1;
                                out_match_next  = 1'b0;
                                out_status_next = err_reg;
                                if (cmd.last) begin
                                    cursor_next = '0;
                                    length_next = '0;
                                    err_next    = STATUS_OK;
                                end
                            end else if (length_reg >= LEN_W'(MAX_LEN)) begin
                                out_valid_next  = 1'b1;
                                out_match_next  = 1'b0;
                                out_status_next = STATUS_LONG;
                                if (cmd.last) begin
                                    cursor_next = '0;
                                    length_next = '0;
                                    err_next    = STATUS_OK;
                                end else begin
                                    err_next = STATUS_LONG;
                                end
                            end else begin
                                mem_raddr  = cursor_reg;
                                state_next = ST_I_LOOK;
                            end
                        end
                        default: begin
                            out_valid_next  = 1'b1;
                            out_match_next  = 1'b0;
                            out_status_next = STATUS_OK;
                        end
                    endcase
                end
            end
            ST_Q_WALK: begin
                // one trie level per cycle, newest letter first
                if (rd_row_reg.mark) begin
                    out_valid_next  = 1'b1;
                    out_match_next  = 1'b1;
                    out_status_next = STATUS_OK;
                    state_next      = ST_IDLE;
                end else if (level_reg == fill_reg || walk_child == '0) begin
                    out_valid_next  = 1'b1;
                    out_match_next  = 1'b0;
                    out_status_next = STATUS_OK;
                    state_next      = ST_IDLE;
                end else begin
                    mem_raddr  = walk_child;
                    level_next = level_reg + 1'b1;
                    pos_next   = (pos_reg == '0) ? POS_W'(MAX_LEN - 1) : pos_reg - 1'b1;
                end
            end
            ST_I_LOOK: begin
                if (look_child == '0) begin
                    if (nodes_used_reg == CNT_W'(NODE_COUNT)) begin
                        out_valid_next  = 1'b1;
                        out_match_next  = 1'b0;
                        out_status_next = STATUS_FULL;
                        state_next      = ST_IDLE;
                        if (cmd_last_reg) begin
                            cursor_next = '0;
                            length_next = '0;
                            err_next    = STATUS_OK;
                        end else begin
                            err_next = STATUS_FULL;
                        end
                    end else begin
                        mem_we    = 1'b1;
                        mem_waddr = cursor_reg;
                        mem_wdata = rd_row_reg;
                        mem_wdata.child[cmd_letter_reg] = nodes_used_reg[NODE_W-1:0];
                        new_node_next   = nodes_used_reg[NODE_W-1:0];
                        nodes_used_next = nodes_used_reg + 1'b1;
                        state_next      = ST_I_NEW;
                    end
                end else begin
                    cursor_next = look_child;
                    length_next = length_reg + 1'b1;
                    if (cmd_last_reg) begin
                        mem_raddr  = look_child;
                        state_next = ST_I_MARK;
                    end else begin
                        out_valid_next  = 1'b1;
                        out_match_next  = 1'b0;
                        out_status_next = STATUS_OK;
                        state_next      = ST_IDLE;
                    end
                end
            end
            ST_I_NEW: begin
                mem_we         = 1'b1;
                mem_waddr      = new_node_reg;
                mem_wdata      = '0;
                mem_wdata.mark = cmd_last_reg;
                if (cmd_last_reg) begin
                    cursor_next = '0;
                    length_next = '0;
                    err_next    = STATUS_OK;
                end else begin
                    cursor_next = new_node_reg;
                    length_next = length_reg + 1'b1;
                end
                out_valid_next  = 1'b1;
                out_match_next  = 1'b0;
                out_status_next = STATUS_OK;
                state_next      = ST_IDLE;
            end
            ST_I_MARK: begin
                mem_we          = 1'b1;
                mem_waddr       = cursor_reg;
                mem_wdata       = rd_row_reg;
                mem_wdata.mark  = 1'b1;
                cursor_next     = '0;
                length_next     = '0;
                err_next        = STATUS_OK;
                out_valid_next  = 1'b1;
                out_match_next  = 1'b0;
                out_status_next = STATUS_OK;
                state_next      = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            nodes_used_reg <= CNT_W'(1);
            cursor_reg     <= '0;
            length_reg     <= '0;
            err_reg        <= STATUS_OK;
            head_reg       <= '0;
            fill_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            nodes_used_reg <= nodes_used_next;
            cursor_reg     <= cursor_next;
            length_reg     <= length_next;
            err_reg        <= err_next;
            head_reg       <= head_next;
            fill_reg       <= fill_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        level_reg      <= level_next;
        pos_reg        <= pos_next;
        new_node_reg   <= new_node_next;
        cmd_letter_reg <= cmd_letter_next;
        cmd_last_reg   <= cmd_last_next;
        out_match_reg  <= out_match_next;
        out_status_reg <= out_status_next;
    end

    always_ff @(posedge aclk) begin
        if (ring_we) begin
            ring_reg[head_reg] <= cmd.letter;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            trie_mem[mem_waddr] <= mem_wdata;
        end
        rd_row_reg <= trie_mem[mem_raddr];
    end

    a_nodes_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        nodes_used_reg >= CNT_W'(1) && nodes_used_reg <= CNT_W'(NODE_COUNT))
        else $error("node count out of range");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= LEN_W'(MAX_LEN) && length_reg <= LEN_W'(MAX_LEN))
        else $error("history fill or word length out of range");

    a_walk_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_Q_WALK |-> level_reg <= fill_reg)
        else $error("walk went deeper than the kept history");

    a_err_code: assert property (@(posedge aclk) disable iff (!aresetn)
        err_reg == STATUS_OK || err_reg == STATUS_FULL || err_reg == STATUS_LONG)
        else $error("bad insert error code");

    a_alloc_once: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_I_NEW |-> nodes_used_reg == $past(nodes_used_reg) + 1'b1)
        else $error("node allocated twice for one letter");

endmodule

// ----- rtl/stream_suffix_dictionary_matcher.sv -----
// top level of the stream suffix dictionary matcher
`timescale 1ns / 1ps

// Each input beat is either a dictionary letter (s_tuser = 0) or a stream
// letter (s_tuser = 1); the letter code sits in s_tdata[4:0], and s_tlast
// on a dictionary letter closes the word. Words are sent last letter first.
// Every input beat yields exactly one result beat on the m_ side:
// m_tdata[0] is the match flag of a query, m_tdata[2:1] the insert status
// (0 ok, 1 node table full, 2 word too long).
// Accepted beats go into a two-entry command queue; one engine then
// executes them in order against a row-wide trie memory (one read port,
// one write port, registered read).
// An insert goes from the queue through ST_I_LOOK, and through ST_I_NEW when
// a node is allocated or ST_I_MARK when an existing node ends a word, to the
// result register, unless ST_IDLE rejects it; a query walks the trie in
// ST_Q_WALK. One item is executed at a time; the next one starts once its
// result has been taken from the output register. After reset the engine
// clears the root row of the trie memory in ST_CLEAR and holds s_tready low
// while it does so. Other rows are cleared as their nodes are allocated.
// When the receiver stalls the result stays in the output register, the
// queue keeps accepting beats until it is full, then s_tready falls.

module stream_suffix_dictionary_matcher import ssdm_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [4:0] letter, [7:5] zero
    input  logic        s_tlast,   // word_end
    input  logic        s_tuser,   // [0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // [0] match, [2:1] status, [7:3] zero
);

    logic  cmd_valid;
    cmd_t  cmd;
    logic  cmd_pop;
    logic  init_done;

    ssdm_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .init_done (init_done),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    ssdm_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .init_done (init_done),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// ----- dv/tb_stream_suffix_dictionary_matcher.sv -----
// self-checking testbench for the stream suffix dictionary matcher
`timescale 1ns / 1ps

module tb_stream_suffix_dictionary_matcher;
    import ssdm_pkg::*;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_QUERY  = 1'b1;
    localparam int   WORD_CAP   = 48;
    localparam int   MAX_REPORT = 10;
    localparam int   DRAIN_CYC  = 40;

    typedef struct packed {
        logic [5:0]                        len;
        logic [WORD_CAP-1:0][LETTER_W-1:0] ch;
    } word_t;

    class suffix_match_scoreboard;
        logic [NODE_W-1:0]   child_tab [NODE_COUNT*ALPHABET_SIZE];
        logic                word_mark [NODE_COUNT];
        int                  nodes_alloc;
        int                  cursor;
        int                  word_len;
        logic [STATUS_W-1:0] word_err;
        logic [LETTER_W-1:0] ring [MAX_LEN];
        int                  head;
        int                  fill;
        logic [2:0]          expected_results [$];   // {status, match}
        int                  mismatches;

        function new();
            foreach (child_tab[i]) child_tab[i] = '0;
            foreach (word_mark[i]) word_mark[i] = 1'b0;
            nodes_alloc = 1;
            cursor      = 0;
            word_len    = 0;
            word_err    = STATUS_OK;
            head        = 0;
            fill        = 0;
            mismatches  = 0;
        endfunction

        function void close_word();
            cursor   = 0;
            word_len = 0;
            word_err = STATUS_OK;
        endfunction

        function logic [STATUS_W-1:0] insert_letter(logic [LETTER_W-1:0] ch, logic fin);
            logic [STATUS_W-1:0] st;
            int                  slot;
            int                  nxt;
            if (ch >= ALPHABET_SIZE) return STATUS_OK;
            if (word_err != STATUS_OK) begin
                st = word_err;
                if (fin) close_word();
                return st;
            end
            if (word_len >= MAX_LEN) begin
                word_err = STATUS_LONG;
            end else begin
                slot = cursor * ALPHABET_SIZE + ch;
                nxt  = child_tab[slot];
                if (nxt == 0) begin
                    if (nodes_alloc >= NODE_COUNT) begin
                        word_err = STATUS_FULL;
                    end else begin
                        nxt = nodes_alloc;
                        nodes_alloc++;
                        child_tab[slot] = nxt[NODE_W-1:0];
                    end
                end
                if (word_err == STATUS_OK) begin
                    cursor = nxt;
                    word_len++;
                    if (fin) begin
                        word_mark[nxt] = 1'b1;
                        close_word();
                    end
                    return STATUS_OK;
                end
            end
            st = word_err;
            if (fin) close_word();
            return st;
        endfunction

        function logic walk_stream(logic [LETTER_W-1:0] ch);
            int node;
            int nxt;
            int pos;
            ring[head] = ch;
            head = (head + 1) % MAX_LEN;
            if (fill < MAX_LEN) fill++;
            node = 0;
            for (int i = 0; i < fill; i++) begin
                pos = (head + MAX_LEN - 1 - i) % MAX_LEN;
                if (ring[pos] >= ALPHABET_SIZE) return 1'b0;
                nxt = child_tab[node * ALPHABET_SIZE + ring[pos]];
                if (nxt == 0) return 1'b0;
                if (word_mark[nxt]) return 1'b1;
                node = nxt;
            end
            return 1'b0;
        endfunction

        function void note_beat(logic q, logic [LETTER_W-1:0] ch, logic fin);
            if (q == REQ_QUERY) expected_results.push_back({STATUS_OK, walk_stream(ch)});
            else expected_results.push_back({insert_letter(ch, fin), 1'b0});
        endfunction

        function void check_beat(logic [7:0] data);
            logic [2:0] want;
            if (expected_results.size() == 0) begin
                if (mismatches < MAX_REPORT) $display("unexpected result beat, tdata %h", data);
                mismatches++;
                return;
            end
            want = expected_results.pop_front();
            if (data[0] !== want[0] || data[2:1] !== want[2:1]) begin
                if (mismatches < MAX_REPORT)
                    $display("mismatch: expected match %0d status %0d, got match %0d status %0d",
                             want[0], want[2:1], data[0], data[2:1]);
                mismatches++;
            end
        endfunction
    endclass

    logic       aclk;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tlast;
    logic       s_tuser;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;

    suffix_match_scoreboard sb = new();
    word_t                  dict [$];
    int                     beats_sent = 0;
    bit                     send_burst = 0;
    bit                     recv_burst = 0;

    stream_suffix_dictionary_matcher u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #1_500_000;
        $display("stream_suffix_dictionary_matcher regression: fail");
        $finish;
    end

    task automatic send_beat(input logic q, input logic [LETTER_W-1:0] ch, input logic fin);
        int gap;
        if ($urandom_range(0, 63) == 0) send_burst = !send_burst;
        gap = send_burst ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= q;
        s_tdata  <= {3'b000, ch};
        s_tlast  <= fin;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_beat(q, ch, fin);
        beats_sent++;
    endtask

    function automatic word_t rand_word(int lo, int hi, int span, bit noisy);
        word_t w;
        w     = '0;
        w.len = 6'($urandom_range(lo, hi));
        for (int i = 0; i < w.len; i++)
            w.ch[i] = (noisy && $urandom_range(0, 40) == 0)
                      ? LETTER_W'($urandom_range(26, 31))
                      : LETTER_W'($urandom_range(0, span - 1));
        return w;
    endfunction

    // dictionary words go out last letter first, the first letter closes the word
    task automatic send_word(input word_t w);
        for (int i = w.len - 1; i >= 0; i--) send_beat(REQ_INSERT, w.ch[i], i == 0);
    endtask

    task automatic stream_word(input word_t w);
        for (int i = 0; i < w.len; i++) send_beat(REQ_QUERY, w.ch[i], 1'($urandom_range(0, 1)));
    endtask

    task automatic run_mix(input int stop_at);
        word_t w;
        int    pick;
        while (beats_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 25) begin
                w = rand_word(1, 6, ($urandom_range(0, 1) != 0) ? 4 : ALPHABET_SIZE, 1);
                send_word(w);
                dict.push_back(w);
            end else if (pick < 55 && dict.size() > 0) begin
                repeat ($urandom_range(0, 3))
                    send_beat(REQ_QUERY, LETTER_W'($urandom_range(0, 31)),
                              1'($urandom_range(0, 1)));
                stream_word(dict[$urandom_range(0, dict.size() - 1)]);
            end else if (pick < 85) begin
                repeat ($urandom_range(1, 5))
                    send_beat(REQ_QUERY, LETTER_W'($urandom_range(0, 4)),
                              1'($urandom_range(0, 1)));
            end else if (pick < 88) begin
                send_word(rand_word(MAX_LEN + 1, 40, ALPHABET_SIZE, 1));
            end else begin
                send_beat(1'($urandom_range(0, 1)), LETTER_W'($urandom_range(0, 31)),
                          1'($urandom_range(0, 1)));
            end
        end
    endtask

    initial begin : result_sink
        int stall;
        m_tready <= 1'b0;
        @(posedge aclk);
        forever begin
            if ($urandom_range(0, 63) == 0) recv_burst = !recv_burst;
            stall = recv_burst ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_beat(m_tdata);
    end

    initial begin : stimulus
        word_t w;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;
        s_tuser  <= REQ_INSERT;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // short words, stray out-of-range letters, extremes of the letter code
        send_beat(REQ_INSERT, 5'd0, 1'b1);
        send_beat(REQ_INSERT, 5'd24, 1'b0);
        send_beat(REQ_INSERT, 5'd25, 1'b1);
        send_beat(REQ_INSERT, 5'd31, 1'b1);
        send_beat(REQ_INSERT, 5'd3, 1'b0);
        send_beat(REQ_INSERT, 5'd26, 1'b1);
        send_beat(REQ_INSERT, 5'd2, 1'b1);
        send_beat(REQ_QUERY, 5'd0, 1'b0);
        send_beat(REQ_QUERY, 5'd31, 1'b0);
        send_beat(REQ_QUERY, 5'd25, 1'b1);
        send_beat(REQ_QUERY, 5'd24, 1'b0);
        send_beat(REQ_QUERY, 5'd2, 1'b0);
        send_beat(REQ_QUERY, 5'd3, 1'b1);
        send_beat(REQ_QUERY, 5'd16, 1'b0);
        send_beat(REQ_QUERY, 5'd15, 1'b0);

        // full-length word walked end to end, then an over-long word
        w = rand_word(MAX_LEN, MAX_LEN, ALPHABET_SIZE, 0);
        send_word(w);
        dict.push_back(w);
        stream_word(w);
        send_word(rand_word(MAX_LEN + 1, MAX_LEN + 4, ALPHABET_SIZE, 0));

        run_mix(550);

        // fill the node table with long words
        while (sb.nodes_alloc < NODE_COUNT) begin
            w = rand_word(20, MAX_LEN, ALPHABET_SIZE, 1);
            send_word(w);
            dict.push_back(w);
            if ($urandom_range(0, 3) == 0) stream_word(dict[$urandom_range(0, dict.size() - 1)]);
        end

        run_mix(beats_sent + 200);

        s_tvalid <= 1'b0;
        while (sb.expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYC) @(posedge aclk);
        if (sb.mismatches == 0 && sb.expected_results.size() == 0)
            $display("stream_suffix_dictionary_matcher regression: pass");
        else
            $display("stream_suffix_dictionary_matcher regression: fail");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/ssdm_pkg.sv
rtl/ssdm_front.sv
rtl/ssdm_back.sv
rtl/stream_suffix_dictionary_matcher.sv
dv/tb_stream_suffix_dictionary_matcher.sv
